>>> rtl/scm_pkg.sv
package scm_pkg;

	localparam int KEY_BITS    = 64;
	localparam int COUNT_BITS  = 32;
	localparam int OP_BITS     = 2;
	localparam int IN_DATA_BITS  = ((KEY_BITS + COUNT_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((KEY_BITS + COUNT_BITS + 7) / 8) * 8;
	localparam int OUT_USER_BITS = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [OP_BITS-1:0] {
		KIND_A_ITEM = 2'd0,
		KIND_B_ITEM = 2'd1,
		KIND_A_END  = 2'd2,
		KIND_B_END  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
	} item_t;

	typedef struct packed {
		logic emit_valid;
		logic need_a;
		logic need_b;
		logic merge_done;
		logic protocol_error;
	} flags_t;

endpackage

>>> rtl/sorted_count_merge.sv
// Two-way merge of ascending (key, count) streams that share one input channel.
// Slave channel: s_tuser carries the opcode (item of A, item of B, end of A,
// end of B); s_tdata carries the key in the low bits and the count above it.
// Master channel: one result per accepted item. m_tdata holds the emitted key
// and count (zero when nothing is emitted); m_tuser holds emit_valid, need_a,
// need_b, merge_done and protocol_error from the lowest bit up.
// Equal keys from both streams come out once with the counts summed, saturated.
// An item for a full slot or an ended stream is dropped and flagged.
// A result passes through the front register, one queue entry and the output
// register of the merge stage before it is presented.
// Throughput: one item per cycle while the receiver does not stall; the merge
// stage does its key compare and count add combinationally.
// When the receiver stalls, the output register holds its result, the queue
// fills, and s_tready drops once the front register cannot move on.
// Reset clears the slots, the end marks and every valid flag; nothing is
// presented until the first item has gone through.
module sorted_count_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [scm_pkg::IN_DATA_BITS-1:0]   s_tdata,  // key, count
	input  logic [scm_pkg::OP_BITS-1:0]        s_tuser,  // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [scm_pkg::OUT_DATA_BITS-1:0]  m_tdata,  // out_key, out_count
	output logic [scm_pkg::OUT_USER_BITS-1:0]  m_tuser   // emit_valid, need_a, need_b,
	                                                     // merge_done, protocol_error
);
	import scm_pkg::*;

	logic  f_valid, f_ready, q_valid, q_ready;
	item_t f_item, q_item;

	scm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	scm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	scm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

>>> rtl/scm_front.sv
module scm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [scm_pkg::IN_DATA_BITS-1:0]   s_tdata,  // key, count
	input  logic [scm_pkg::OP_BITS-1:0]        s_tuser,  // opcode
	output logic                               item_valid,
	input  logic                               item_ready,
	output scm_pkg::item_t                     item
);
	import scm_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	always_comb begin
		item_in.kind  = kind_t'(s_tuser);
		item_in.key   = s_tdata[KEY_BITS-1:0];
		item_in.count = s_tdata[KEY_BITS +: COUNT_BITS];
	end

	assign s_tready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

>>> rtl/scm_queue.sv
module scm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  scm_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output scm_pkg::item_t rd_item
);
	import scm_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> rtl/scm_back.sv
module scm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  scm_pkg::item_t                     item,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [scm_pkg::OUT_DATA_BITS-1:0]  m_tdata,  // out_key, out_count
	output logic [scm_pkg::OUT_USER_BITS-1:0]  m_tuser   // emit_valid, need_a, need_b,
	                                                     // merge_done, protocol_error
);
	import scm_pkg::*;

	logic [KEY_BITS-1:0]   a_key_q, b_key_q;
	logic [COUNT_BITS-1:0] a_cnt_q, b_cnt_q;
	logic                  a_full_q, b_full_q, a_end_q, b_end_q;

	logic [KEY_BITS-1:0]   a_key_d, b_key_d;
	logic [COUNT_BITS-1:0] a_cnt_d, b_cnt_d;
	logic                  a_full_d, b_full_d, a_end_d, b_end_d;

	logic                  out_valid_q;
	logic [KEY_BITS-1:0]   out_key_q, key_d;
	logic [COUNT_BITS-1:0] out_cnt_q, cnt_d;
	flags_t                flags_q, flags_d;
	logic [COUNT_BITS:0]   sum;
	logic                  step;

	assign item_ready = !out_valid_q || m_tready;
	assign step       = item_valid && item_ready;

	always_comb begin
		a_key_d  = a_key_q;
		a_cnt_d  = a_cnt_q;
		a_full_d = a_full_q;
		a_end_d  = a_end_q;
		b_key_d  = b_key_q;
		b_cnt_d  = b_cnt_q;
		b_full_d = b_full_q;
		b_end_d  = b_end_q;
		flags_d  = '0;
		key_d    = '0;
		cnt_d    = '0;

		unique case (item.kind)
			KIND_A_ITEM: begin
				if (a_full_q || a_end_q) begin
					flags_d.protocol_error = 1'b1;
				end else begin
					a_key_d  = item.key;
					a_cnt_d  = item.count;
					a_full_d = 1'b1;
				end
			end
			KIND_B_ITEM: begin
				if (b_full_q || b_end_q) begin
					flags_d.protocol_error = 1'b1;
				end else begin
					b_key_d  = item.key;
					b_cnt_d  = item.count;
					b_full_d = 1'b1;
				end
			end
			KIND_A_END: a_end_d = 1'b1;
			KIND_B_END: b_end_d = 1'b1;
			default: ;
		endcase

		sum = {1'b0, a_cnt_d} + {1'b0, b_cnt_d};

		priority if (a_full_d && b_full_d) begin
			flags_d.emit_valid = 1'b1;
			priority if (a_key_d < b_key_d) begin
				key_d    = a_key_d;
				cnt_d    = a_cnt_d;
				a_full_d = 1'b0;
			end else if (b_key_d < a_key_d) begin
				key_d    = b_key_d;
				cnt_d    = b_cnt_d;
				b_full_d = 1'b0;
			end else begin
				key_d    = a_key_d;
				cnt_d    = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
				a_full_d = 1'b0;
				b_full_d = 1'b0;
			end
		end else if (a_full_d && b_end_d) begin
			flags_d.emit_valid = 1'b1;
			key_d    = a_key_d;
			cnt_d    = a_cnt_d;
			a_full_d = 1'b0;
		end else if (b_full_d && a_end_d) begin
			flags_d.emit_valid = 1'b1;
			key_d    = b_key_d;
			cnt_d    = b_cnt_d;
			b_full_d = 1'b0;
		end else begin
		end

		if (a_end_d && b_end_d && !a_full_d && !b_full_d) begin
			flags_d.merge_done = 1'b1;
			a_end_d = 1'b0;
			b_end_d = 1'b0;
		end

		flags_d.need_a = !a_full_d && !a_end_d;
		flags_d.need_b = !b_full_d && !b_end_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_full_q    <= 1'b0;
			b_full_q    <= 1'b0;
			a_end_q     <= 1'b0;
			b_end_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				a_full_q <= a_full_d;
				b_full_q <= b_full_d;
				a_end_q  <= a_end_d;
				b_end_q  <= b_end_d;
			end
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			a_key_q   <= a_key_d;
			a_cnt_q   <= a_cnt_d;
			b_key_q   <= b_key_d;
			b_cnt_q   <= b_cnt_d;
			out_key_q <= key_d;
			out_cnt_q <= cnt_d;
			flags_q   <= flags_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'({out_cnt_q, out_key_q});
	assign m_tuser  = {flags_q.protocol_error, flags_q.merge_done, flags_q.need_b,
		flags_q.need_a, flags_q.emit_valid};

endmodule

>>> sim/tb_sorted_count_merge.sv
`timescale 1ns / 100ps
module tb_sorted_count_merge;
	import scm_pkg::*;

	typedef struct packed {
		logic                  emit_valid;
		logic [KEY_BITS-1:0]   out_key;
		logic [COUNT_BITS-1:0] out_count;
		logic                  need_a;
		logic                  need_b;
		logic                  merge_done;
		logic                  protocol_error;
	} merge_result_t;

	typedef struct {
		kind_t                 kind;
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
		bit                    typed;
		merge_result_t         res;
	} stim_row_t;

	localparam int U_EMIT   = 0;
	localparam int U_NEED_A = 1;
	localparam int U_NEED_B = 2;
	localparam int U_DONE   = 3;
	localparam int U_ERR    = 4;

	localparam logic [KEY_BITS-1:0]   KEY_MAX   = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [OP_BITS-1:0]       s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [OUT_USER_BITS-1:0] m_tuser;

	logic [KEY_BITS-1:0]   pend_a_key;
	logic [KEY_BITS-1:0]   pend_b_key;
	logic [COUNT_BITS-1:0] pend_a_cnt;
	logic [COUNT_BITS-1:0] pend_b_cnt;
	bit                    pend_a_full;
	bit                    pend_b_full;
	bit                    a_closed;
	bit                    b_closed;

	merge_result_t merge_results_due[$];
	stim_row_t     directed_rows[$];
	int            fails;
	int            items_sent;
	int            send_idle_pct;
	int            stall_pct;

	sorted_count_merge i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic merge_result_t merge_step(kind_t kind, logic [KEY_BITS-1:0] key,
			logic [COUNT_BITS-1:0] cnt);
		merge_result_t r;
		logic [COUNT_BITS:0] sum;
		r = '0;
		case (kind)
			KIND_A_ITEM: begin
				if (pend_a_full || a_closed) begin
					r.protocol_error = 1'b1;
				end else begin
					pend_a_key  = key;
					pend_a_cnt  = cnt;
					pend_a_full = 1'b1;
				end
			end
			KIND_B_ITEM: begin
				if (pend_b_full || b_closed) begin
					r.protocol_error = 1'b1;
				end else begin
					pend_b_key  = key;
					pend_b_cnt  = cnt;
					pend_b_full = 1'b1;
				end
			end
			KIND_A_END: a_closed = 1'b1;
			default: b_closed = 1'b1;
		endcase
		if (pend_a_full && pend_b_full) begin
			r.emit_valid = 1'b1;
			if (pend_a_key < pend_b_key) begin
				r.out_key   = pend_a_key;
				r.out_count = pend_a_cnt;
				pend_a_full = 1'b0;
			end else if (pend_b_key < pend_a_key) begin
				r.out_key   = pend_b_key;
				r.out_count = pend_b_cnt;
				pend_b_full = 1'b0;
			end else begin
				sum         = {1'b0, pend_a_cnt} + {1'b0, pend_b_cnt};
				r.out_key   = pend_a_key;
				r.out_count = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
				pend_a_full = 1'b0;
				pend_b_full = 1'b0;
			end
		end else if (pend_a_full && b_closed) begin
			r.emit_valid = 1'b1;
			r.out_key    = pend_a_key;
			r.out_count  = pend_a_cnt;
			pend_a_full  = 1'b0;
		end else if (pend_b_full && a_closed) begin
			r.emit_valid = 1'b1;
			r.out_key    = pend_b_key;
			r.out_count  = pend_b_cnt;
			pend_b_full  = 1'b0;
		end
		if (a_closed && b_closed && !pend_a_full && !pend_b_full) begin
			r.merge_done = 1'b1;
			a_closed     = 1'b0;
			b_closed     = 1'b0;
		end
		r.need_a = !pend_a_full && !a_closed;
		r.need_b = !pend_b_full && !b_closed;
		return r;
	endfunction

	function automatic merge_result_t want_res(logic e, logic [KEY_BITS-1:0] k,
			logic [COUNT_BITS-1:0] c, logic na, logic nb, logic d, logic er);
		merge_result_t r;
		r.emit_valid     = e;
		r.out_key        = k;
		r.out_count      = c;
		r.need_a         = na;
		r.need_b         = nb;
		r.merge_done     = d;
		r.protocol_error = er;
		return r;
	endfunction

	function automatic logic [COUNT_BITS-1:0] rand_count();
		case ($urandom_range(0, 7))
			0: return COUNT_MAX - COUNT_BITS'($urandom_range(0, 15));
			1: return COUNT_BITS'($urandom_range(0, 3));
			default: return COUNT_BITS'($urandom);
		endcase
	endfunction

	task automatic add_row(kind_t kind, logic [KEY_BITS-1:0] key, logic [COUNT_BITS-1:0] cnt,
			bit typed, merge_result_t res);
		stim_row_t row;
		row.kind  = kind;
		row.key   = key;
		row.count = cnt;
		row.typed = typed;
		row.res   = res;
		directed_rows = {directed_rows, row};
	endtask

	task automatic send_item(kind_t kind, logic [KEY_BITS-1:0] key, logic [COUNT_BITS-1:0] cnt,
			bit typed, merge_result_t typed_res);
		merge_result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {cnt, key};
		do @(posedge clk); while (!s_tready);
		r = merge_step(kind, key, cnt);
		merge_results_due = {merge_results_due, typed ? typed_res : r};
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (merge_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_merge();
		logic [KEY_BITS-1:0]   a_keys[$];
		logic [KEY_BITS-1:0]   b_keys[$];
		logic [COUNT_BITS-1:0] a_cnts[$];
		logic [COUNT_BITS-1:0] b_cnts[$];
		logic [KEY_BITS-1:0]   k;
		int                    n;
		int                    mode;
		int                    side;
		bit                    a_end_sent;
		bit                    b_end_sent;
		bit                    ok_a;
		bit                    ok_b;
		bit                    ok_ea;
		bit                    ok_eb;
		kind_t                 op;
		n    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		mode = $urandom_range(0, 5);
		k    = (mode == 0) ? '0 : (mode == 1) ? KEY_MAX - KEY_BITS'(50) : {$urandom, $urandom};
		for (int i = 0; i < n; i++) begin
			side = $urandom_range(0, 2);
			if (side != 1) begin
				a_keys = {a_keys, k};
				a_cnts = {a_cnts, rand_count()};
			end
			if (side != 0) begin
				b_keys = {b_keys, k};
				b_cnts = {b_cnts, rand_count()};
			end
			k += ($urandom_range(0, 7) == 0) ? KEY_BITS'($urandom) : KEY_BITS'($urandom_range(1, 4));
		end
		a_end_sent = 1'b0;
		b_end_sent = 1'b0;
		while (a_keys.size() != 0 || b_keys.size() != 0 || !a_end_sent || !b_end_sent) begin
			if ($urandom_range(0, 99) < 6) begin
				send_item(kind_t'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom, 1'b0, '0);
			end else begin
				ok_a  = a_keys.size() != 0 && !pend_a_full;
				ok_b  = b_keys.size() != 0 && !pend_b_full;
				ok_ea = a_keys.size() == 0 && !a_end_sent;
				ok_eb = b_keys.size() == 0 && !b_end_sent;
				op    = kind_t'($urandom_range(0, 3));
				if (!(ok_a || ok_b || ok_ea || ok_eb)) begin
					op = (a_keys.size() != 0) ? KIND_A_ITEM : KIND_B_ITEM;
				end else begin
					while (!((op == KIND_A_ITEM && ok_a) || (op == KIND_B_ITEM && ok_b) ||
							(op == KIND_A_END && ok_ea) || (op == KIND_B_END && ok_eb)))
						op = kind_t'((int'(op) + 1) % 4);
				end
				case (op)
					KIND_A_ITEM: send_item(op, a_keys.pop_front(), a_cnts.pop_front(), 1'b0, '0);
					KIND_B_ITEM: send_item(op, b_keys.pop_front(), b_cnts.pop_front(), 1'b0, '0);
					KIND_A_END: begin
						send_item(op, {$urandom, $urandom}, $urandom, 1'b0, '0);
						a_end_sent = 1'b1;
					end
					default: begin
						send_item(op, {$urandom, $urandom}, $urandom, 1'b0, '0);
						b_end_sent = 1'b1;
					end
				endcase
			end
		end
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(negedge clk)
		m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin : watch_results
		merge_result_t got;
		merge_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.emit_valid     = m_tuser[U_EMIT];
			got.need_a         = m_tuser[U_NEED_A];
			got.need_b         = m_tuser[U_NEED_B];
			got.merge_done     = m_tuser[U_DONE];
			got.protocol_error = m_tuser[U_ERR];
			got.out_key        = m_tdata[KEY_BITS-1:0];
			got.out_count      = m_tdata[KEY_BITS +: COUNT_BITS];
			if (merge_results_due.size() == 0) begin
				$display("%0t: unexpected result expected none got key %h count %h flags %b",
					$time, got.out_key, got.out_count, m_tuser);
				fails++;
			end else begin
				want = merge_results_due.pop_front();
				compare_field("emit_valid", 64'(want.emit_valid), 64'(got.emit_valid));
				compare_field("out_key", 64'(want.out_key), 64'(got.out_key));
				compare_field("out_count", 64'(want.out_count), 64'(got.out_count));
				compare_field("need_a", 64'(want.need_a), 64'(got.need_a));
				compare_field("need_b", 64'(want.need_b), 64'(got.need_b));
				compare_field("merge_done", 64'(want.merge_done), 64'(got.merge_done));
				compare_field("protocol_error", 64'(want.protocol_error),
					64'(got.protocol_error));
			end
		end
	end

	initial begin
		#3000000;
		$display("** sorted_count_merge: FAILED **");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = KIND_A_ITEM;
		s_tdata       = '0;
		m_tready      = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		fails         = 0;
		items_sent    = 0;
		pend_a_key    = '0;
		pend_b_key    = '0;
		pend_a_cnt    = '0;
		pend_b_cnt    = '0;
		pend_a_full   = 1'b0;
		pend_b_full   = 1'b0;
		a_closed      = 1'b0;
		b_closed      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(KIND_A_ITEM, '0, '0, 1'b1,
			want_res(1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
		add_row(KIND_A_ITEM, 64'd5, 32'd5, 1'b1,
			want_res(1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
		add_row(KIND_B_ITEM, '0, COUNT_MAX, 1'b1,
			want_res(1'b1, '0, COUNT_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
		add_row(KIND_A_ITEM, KEY_MAX, COUNT_MAX, 1'b1,
			want_res(1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
		add_row(KIND_B_ITEM, KEY_MAX, 32'd1, 1'b1,
			want_res(1'b1, KEY_MAX, COUNT_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
		add_row(KIND_A_ITEM, 64'd10, 32'd3, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd20, 32'd4, 1'b0, '0);
		add_row(KIND_A_ITEM, 64'd30, 32'd7, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd40, 32'd2, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd50, 32'd9, 1'b1,
			want_res(1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
		add_row(KIND_A_END, '0, '0, 1'b0, '0);
		add_row(KIND_A_ITEM, 64'd99, 32'd1, 1'b1,
			want_res(1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
		add_row(KIND_A_END, KEY_MAX, COUNT_MAX, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd60, 32'd8, 1'b0, '0);
		add_row(KIND_B_END, '0, '0, 1'b1,
			want_res(1'b0, '0, '0, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(KIND_B_END, '0, '0, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd5, 32'd5, 1'b1,
			want_res(1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));
		add_row(KIND_A_ITEM, 64'd70, 32'd1, 1'b0, '0);
		add_row(KIND_A_END, '0, '0, 1'b0, '0);
		add_row(KIND_A_ITEM, 64'd75, 32'd1, 1'b0, '0);
		add_row(KIND_A_END, '0, '0, 1'b0, '0);
		add_row(KIND_B_END, '0, '0, 1'b1,
			want_res(1'b1, 64'd75, 32'd1, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(KIND_A_ITEM, 64'd100, 32'd1, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd50, 32'd2, 1'b0, '0);
		add_row(KIND_B_ITEM, 64'd40, 32'd3, 1'b0, '0);

		foreach (directed_rows[i])
			send_item(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].count,
				directed_rows[i].typed, directed_rows[i].res);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			send_idle_pct = (p == 1) ? 88 : (p == 3) ? 15 : 0;
			stall_pct     = (p == 2) ? 88 : (p == 3) ? 15 : 0;
			for (int t = items_sent + 288; items_sent < t; )
				run_merge();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (merge_results_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, merge_results_due.size());
			fails++;
		end
		if (fails == 0)
			$display("** sorted_count_merge: PASSED **");
		else
			$display("** sorted_count_merge: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/scm_pkg.sv
rtl/scm_front.sv
rtl/scm_queue.sv
rtl/scm_back.sv
rtl/sorted_count_merge.sv
sim/tb_sorted_count_merge.sv
